[src/array_focus_phase_unit_macros.svh]
// assertion macros shared by the array focus phase unit
// no dependencies; included by files that carry concurrent checks
`ifndef ARRAY_FOCUS_PHASE_UNIT_MACROS_SVH
`define ARRAY_FOCUS_PHASE_UNIT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define AFP_CHECK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define AFP_CHECK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/afp_pkg.sv]
// shared types, constants and the column height table of the focus phase unit
// no dependencies
`default_nettype none

package afp_pkg;

	localparam int CENTRE_COL = 15;
	localparam int Y_BASE     = 27;
	localparam int FULL_TURN  = 46080;
	localparam int TERM_SCALE = 23040;

	localparam int N_W     = 80;  // radicand, padded to an even bit count
	localparam int ROOT_W  = N_W / 2;
	localparam int REM_W   = ROOT_W + 2;
	localparam int DIST_W  = 39;
	localparam int NUM_W   = 55;
	localparam int PHASE_W = 16;

	localparam logic [1:0] REG_SCALE_X      = 2'd0;
	localparam logic [1:0] REG_SCALE_Y      = 2'd1;
	localparam logic [1:0] REG_FOCUS_RADIUS = 2'd2;
	localparam logic [1:0] REG_WAVELENGTH   = 2'd3;

	typedef struct packed {
		logic       in_range;
		logic [4:0] coord_x;
		logic [5:0] coord_y;
	} side_t;

	function automatic logic [4:0] col_height(input logic [4:0] col);
		logic [4:0] h;
		case (col)
			5'd0:  h = 5'd4;
			5'd1:  h = 5'd11;
			5'd2:  h = 5'd14;
			5'd3:  h = 5'd17;
			5'd4:  h = 5'd18;
			5'd5:  h = 5'd19;
			5'd6:  h = 5'd22;
			5'd7:  h = 5'd23;
			5'd8:  h = 5'd24;
			5'd9:  h = 5'd25;
			5'd10: h = 5'd24;
			5'd11: h = 5'd25;
			5'd12: h = 5'd26;
			5'd13: h = 5'd27;
			5'd14: h = 5'd26;
			5'd15: h = 5'd27;
			5'd16: h = 5'd26;
			5'd17: h = 5'd27;
			5'd18: h = 5'd26;
			5'd19: h = 5'd25;
			5'd20: h = 5'd24;
			5'd21: h = 5'd25;
			5'd22: h = 5'd24;
			5'd23: h = 5'd23;
			5'd24: h = 5'd22;
			5'd25: h = 5'd19;
			5'd26: h = 5'd18;
			5'd27: h = 5'd17;
			5'd28: h = 5'd14;
			5'd29: h = 5'd11;
			5'd30: h = 5'd4;
			default: h = 5'd0;
		endcase
		return h;
	endfunction

endpackage

`default_nettype wire

[src/afp_geom.sv]
// element geometry stage: column height lookup, grid coordinates, doubled offsets
// depends on afp_pkg
`default_nettype none

module afp_geom #(
	parameter int NUM_COLUMNS = 31
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           valid_in,
	input  wire logic [4:0]     column,
	input  wire logic [4:0]     row,
	output afp_pkg::side_t      side_s1,
	output logic                valid_s1,
	output logic [4:0]          x2_s1,
	output logic [4:0]          y2_s1
);

	logic [4:0]        e;
	logic              ok;
	logic [3:0]        xd;
	logic [3:0]        half;
	logic signed [6:0] yt;
	logic signed [6:0] ya;
	logic [5:0]        cy;

	always_comb begin
		e  = (int'(column) < NUM_COLUMNS) ? afp_pkg::col_height(column) : 5'd0;
		ok = (row < e);
		xd = (column >= 5'(afp_pkg::CENTRE_COL)) ? 4'(column - 5'(afp_pkg::CENTRE_COL))
			: 4'(5'(afp_pkg::CENTRE_COL) - column);
		// odd columns centre on an element, even ones between two
		half = column[0] ? 4'((e - 5'd1) >> 1) : 4'(e >> 1);
		yt = $signed({2'b00, half, 1'b0}) - $signed({1'b0, row, 1'b0})
			- (column[0] ? 7'sd0 : 7'sd1);
		ya = (yt < 7'sd0) ? -yt : yt;
		cy = 6'(7'(afp_pkg::Y_BASE) - {2'b00, e} + {1'b0, row, 1'b0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.in_range <= ok;
			side_s1.coord_x  <= ok ? column : 5'd0;
			side_s1.coord_y  <= ok ? cy : 6'd0;
			x2_s1            <= {xd, 1'b0};
			y2_s1            <= 5'(ya);
		end
	end

endmodule

`default_nettype wire

[src/afp_sumsq.sv]
// sum of squares a^2 + b^2 + c^2 over three stages
// depends on afp_pkg
`default_nettype none

module afp_sumsq (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    valid_in,
	input  wire afp_pkg::side_t          side_in,
	input  wire logic [4:0]              x2,
	input  wire logic [4:0]              y2,
	input  wire logic [31:0]             scale_x,
	input  wire logic [31:0]             scale_y,
	input  wire logic [31:0]             focus_radius,
	output logic                         valid_s4,
	output afp_pkg::side_t               side_s4,
	output logic [afp_pkg::N_W-1:0]      n_s4
);

	logic           valid_s2, valid_s3;
	afp_pkg::side_t side_s2, side_s3;
	logic [63:0]    sxsq_s2, sysq_s2, rsq_s2;
	logic [9:0]     x2sq_s2, y2sq_s2;
	logic [73:0]    ax_s3, by_s3;
	logic [65:0]    c2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_in;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_in;
			sxsq_s2 <= 64'(scale_x) * 64'(scale_x);
			sysq_s2 <= 64'(scale_y) * 64'(scale_y);
			rsq_s2  <= 64'(focus_radius) * 64'(focus_radius);
			x2sq_s2 <= 10'(x2) * 10'(x2);
			y2sq_s2 <= 10'(y2) * 10'(y2);

			side_s3 <= side_s2;
			ax_s3   <= 74'(sxsq_s2) * 74'(x2sq_s2);
			by_s3   <= 74'(sysq_s2) * 74'(y2sq_s2);
			c2_s3   <= {rsq_s2, 2'b00};

			side_s4 <= side_s3;
			n_s4    <= afp_pkg::N_W'(ax_s3) + afp_pkg::N_W'(by_s3) + afp_pkg::N_W'(c2_s3);
		end
	end

endmodule

`default_nettype wire

[src/afp_sqrt.sv]
// pipelined floor square root, one root bit per stage
// depends on afp_pkg
`default_nettype none

module afp_sqrt (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       valid_in,
	input  wire afp_pkg::side_t             side_in,
	input  wire logic [afp_pkg::N_W-1:0]    n_in,
	output logic                            valid_out,
	output afp_pkg::side_t                  side_out,
	output logic [afp_pkg::ROOT_W-1:0]      root_out
);

	localparam int NST = afp_pkg::ROOT_W;
	localparam int RW  = afp_pkg::REM_W;
	localparam int NW  = afp_pkg::N_W;
	localparam int QW  = afp_pkg::ROOT_W;

	logic           v_q    [1:NST];
	afp_pkg::side_t side_q [1:NST];
	logic [NW-1:0]  n_q    [1:NST];
	logic [RW-1:0]  rem_q  [1:NST];
	logic [QW-1:0]  root_q [1:NST];

	for (genvar i = 0; i < NST; i++) begin : g_stage
		logic           v_i;
		afp_pkg::side_t side_i;
		logic [NW-1:0]  n_i;
		logic [RW-1:0]  rem_i;
		logic [QW-1:0]  root_i;
		logic [RW+1:0]  cur, trial;
		logic           ge;

		if (i == 0) begin : g_first
			assign v_i    = valid_in;
			assign side_i = side_in;
			assign n_i    = n_in;
			assign rem_i  = '0;
			assign root_i = '0;
		end else begin : g_next
			assign v_i    = v_q[i];
			assign side_i = side_q[i];
			assign n_i    = n_q[i];
			assign rem_i  = rem_q[i];
			assign root_i = root_q[i];
		end

		always_comb begin
			cur   = {rem_i, n_i[NW-1 -: 2]};
			trial = {2'b00, root_i, 2'b01};
			ge    = (cur >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i+1] <= 1'b0;
			end else if (en) begin
				v_q[i+1] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_q[i+1] <= side_i;
				n_q[i+1]    <= {n_i[NW-3:0], 2'b00};
				rem_q[i+1]  <= RW'(ge ? (cur - trial) : cur);
				root_q[i+1] <= {root_i[QW-2:0], ge};
			end
		end
	end

	assign valid_out = v_q[NST];
	assign side_out  = side_q[NST];
	assign root_out  = root_q[NST];

endmodule

`default_nettype wire

[src/afp_div.sv]
// path term ceil(23040*d/lambda) by a restoring divider, one quotient bit per
// stage, quotient kept modulo a full turn; ends in the output register. uses afp_pkg
`default_nettype none

module afp_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          valid_in,
	input  wire afp_pkg::side_t                side_in,
	input  wire logic [afp_pkg::ROOT_W-1:0]    root,
	input  wire logic [31:0]                   focus_radius,
	input  wire logic [31:0]                   wavelength,
	output logic                               valid_out,
	output afp_pkg::side_t                     side_out,
	output logic [afp_pkg::PHASE_W-1:0]        phase_out
);

	localparam int NST = afp_pkg::NUM_W;
	localparam int NW  = afp_pkg::NUM_W;
	localparam int DW  = afp_pkg::DIST_W;
	localparam int PW  = afp_pkg::PHASE_W;

	logic [31:0]    lam;
	logic           valid_p0, valid_p1;
	afp_pkg::side_t side_p0, side_p1;
	logic [DW-1:0]  d_p0;
	logic [NW-1:0]  num_p1;

	logic           v_q    [1:NST];
	afp_pkg::side_t side_q [1:NST];
	logic [NW-1:0]  num_q  [1:NST];
	logic [31:0]    rem_q  [1:NST];
	logic [PW-1:0]  qm_q   [1:NST];

	// a zero wavelength divides as one
	assign lam = (wavelength == 32'd0) ? 32'd1 : wavelength;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_p0 <= 1'b0;
			valid_p1 <= 1'b0;
		end else if (en) begin
			valid_p0 <= valid_in;
			valid_p1 <= valid_p0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_p0 <= side_in;
			d_p0    <= DW'(root - afp_pkg::ROOT_W'({focus_radius, 1'b0}));
			side_p1 <= side_p0;
			// adding lambda-1 makes the floor division a ceiling
			num_p1  <= NW'(NW'(d_p0) * NW'(afp_pkg::TERM_SCALE)) + NW'(lam) - NW'(1);
		end
	end

	for (genvar i = 0; i < NST; i++) begin : g_stage
		logic           v_i;
		afp_pkg::side_t side_i;
		logic [NW-1:0]  num_i;
		logic [31:0]    rem_i;
		logic [PW-1:0]  qm_i;
		logic [32:0]    cur;
		logic           ge;
		logic [PW:0]    q2;

		if (i == 0) begin : g_first
			assign v_i    = valid_p1;
			assign side_i = side_p1;
			assign num_i  = num_p1;
			assign rem_i  = '0;
			assign qm_i   = '0;
		end else begin : g_next
			assign v_i    = v_q[i];
			assign side_i = side_q[i];
			assign num_i  = num_q[i];
			assign rem_i  = rem_q[i];
			assign qm_i   = qm_q[i];
		end

		always_comb begin
			cur = {rem_i, num_i[NW-1]};
			ge  = (cur >= {1'b0, lam});
			q2  = {qm_i, ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i+1] <= 1'b0;
			end else if (en) begin
				v_q[i+1] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_q[i+1] <= side_i;
				num_q[i+1]  <= {num_i[NW-2:0], 1'b0};
				rem_q[i+1]  <= 32'(ge ? (cur - {1'b0, lam}) : cur);
				qm_q[i+1]   <= (q2 >= (PW+1)'(afp_pkg::FULL_TURN))
					? PW'(q2 - (PW+1)'(afp_pkg::FULL_TURN)) : PW'(q2);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= v_q[NST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_out <= side_q[NST];
			if (!side_q[NST].in_range || qm_q[NST] == '0) begin
				phase_out <= '0;
			end else begin
				phase_out <= PW'(afp_pkg::FULL_TURN) - qm_q[NST];
			end
		end
	end

endmodule

`default_nettype wire

[src/array_focus_phase_unit.sv]
// top level of the array focus phase unit: register port and the pipeline
// depends on afp_pkg, afp_geom, afp_sumsq, afp_sqrt, afp_div and the macro header
//
// Usage: an element beat (column, row) enters on in_valid when in_stall is low;
// one result beat (in_range, coord_x, coord_y, phase) leaves on out_valid and is
// taken when out_stall is low. Results come out in input order, one per element.
// The pipeline holds 1 geometry stage, 3 square stages, 40 square-root stages
// (one root bit each), 2 stages forming the dividend, 55 divider stages (one
// quotient bit each) and the output register. Throughput: one element per clock
// while out_stall holds no waiting result.
// When out_stall holds a waiting result the whole pipeline freezes and in_stall
// rises; nothing is dropped or repeated, and bubbles ride along as invalid stages.
// Reset clears all valid bits and sets scale_x = scale_y = wavelength = 1.0 and
// focus_radius = 0 (Q16.16). Registers sit at byte addresses 0, 4, 8, 12; the user
// must write them only while no element is in flight; the block does not enforce it.
// Elements outside the array give in_range = 0 with zero coordinates and phase.
`default_nettype none
`include "array_focus_phase_unit_macros.svh"

module array_focus_phase_unit #(
	parameter int NUM_COLUMNS = 31
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [4:0]  column,
	input  wire logic [4:0]  row,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             in_range,
	output logic [4:0]       coord_x,
	output logic [5:0]       coord_y,
	output logic [15:0]      phase,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [31:0] scale_x_q, scale_y_q, focus_radius_q, wavelength_q;
	logic        adv;

	logic                              valid_s1;
	afp_pkg::side_t                    side_s1;
	logic [4:0]                        x2_s1, y2_s1;
	logic                              valid_s4;
	afp_pkg::side_t                    side_s4;
	logic [afp_pkg::N_W-1:0]           n_s4;
	logic                              sq_valid;
	afp_pkg::side_t                    sq_side;
	logic [afp_pkg::ROOT_W-1:0]        sq_root;
	afp_pkg::side_t                    out_side;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q      <= 32'd65536;
			scale_y_q      <= 32'd65536;
			focus_radius_q <= 32'd0;
			wavelength_q   <= 32'd65536;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				afp_pkg::REG_SCALE_X:      scale_x_q      <= pwdata;
				afp_pkg::REG_SCALE_Y:      scale_y_q      <= pwdata;
				afp_pkg::REG_FOCUS_RADIUS: focus_radius_q <= pwdata;
				afp_pkg::REG_WAVELENGTH:   wavelength_q   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			afp_pkg::REG_SCALE_X:      prdata = scale_x_q;
			afp_pkg::REG_SCALE_Y:      prdata = scale_y_q;
			afp_pkg::REG_FOCUS_RADIUS: prdata = focus_radius_q;
			afp_pkg::REG_WAVELENGTH:   prdata = wavelength_q;
			default:                   prdata = 32'd0;
		endcase
	end

	// the pipeline moves whenever the output beat is free or being taken
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	afp_geom #(
		.NUM_COLUMNS(NUM_COLUMNS)
	) u_geom (
		.clk(clk), .arst_n(arst_n), .en(adv), .valid_in(in_valid),
		.column(column), .row(row),
		.side_s1(side_s1), .valid_s1(valid_s1), .x2_s1(x2_s1), .y2_s1(y2_s1)
	);

	afp_sumsq u_sumsq (
		.clk(clk), .arst_n(arst_n), .en(adv), .valid_in(valid_s1), .side_in(side_s1),
		.x2(x2_s1), .y2(y2_s1),
		.scale_x(scale_x_q), .scale_y(scale_y_q), .focus_radius(focus_radius_q),
		.valid_s4(valid_s4), .side_s4(side_s4), .n_s4(n_s4)
	);

	afp_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(adv), .valid_in(valid_s4), .side_in(side_s4),
		.n_in(n_s4),
		.valid_out(sq_valid), .side_out(sq_side), .root_out(sq_root)
	);

	afp_div u_div (
		.clk(clk), .arst_n(arst_n), .en(adv), .valid_in(sq_valid), .side_in(sq_side),
		.root(sq_root), .focus_radius(focus_radius_q), .wavelength(wavelength_q),
		.valid_out(out_valid), .side_out(out_side), .phase_out(phase)
	);

	assign in_range = out_side.in_range;
	assign coord_x  = out_side.coord_x;
	assign coord_y  = out_side.coord_y;

	`AFP_CHECK(a_phase_wrapped, clk, arst_n, !out_valid || phase < 16'd46080, "phase not below a full turn")
	`AFP_CHECK(a_outside_zero, clk, arst_n, !(out_valid && !in_range) || (phase == 16'd0 && coord_x == 5'd0 && coord_y == 6'd0), "out-of-range element with nonzero fields")
	`AFP_CHECK(a_coord_bounds, clk, arst_n, !(out_valid && in_range) || (coord_x < 5'd31 && coord_y <= 6'd52), "coordinates beyond the array grid")
	`AFP_CHECK_NEXT(a_accept_enters, clk, arst_n, in_valid && !in_stall, valid_s1, "accepted beat missing from first stage")

endmodule

`default_nettype wire
